### hw/rtl/ales_pkg.sv
// ales_pkg: shared sizes, codes and word types for the adjacency list edge store.
// Used by the top level and the port checker.
`timescale 1ns / 1ps

package ales_pkg;

   localparam int MAX_VERTICES = 128;
   localparam int LIST_DEPTH   = 16;
   localparam int WEIGHT_BITS  = 16;

   localparam int VTX_BITS        = $clog2(MAX_VERTICES);
   localparam int IDX_BITS        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LEN_BITS        = $clog2(LIST_DEPTH + 1);
   localparam int ENTRY_DEPTH     = MAX_VERTICES * LIST_DEPTH;
   localparam int ENTRY_ADDR_BITS = $clog2(ENTRY_DEPTH);
   localparam int EDGE_BITS       = $clog2(ENTRY_DEPTH + 1);
   localparam int CFG_BITS        = 8;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 8'd128;
   localparam logic [CFG_BITS-1:0] VTX_CAP   = CFG_BITS'(MAX_VERTICES);
   localparam logic [LEN_BITS-1:0] LEN_FULL  = LEN_BITS'(LIST_DEPTH);

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_EXISTS = 3'd2;
   localparam logic [2:0] OP_LIST   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;
   localparam logic [1:0] STATUS_BAD_VERTEX = 2'd3;

   typedef struct packed {
      logic [2:0]         operation;
      logic [6:0]         source_vertex;
      logic [6:0]         target_vertex;
      logic signed [15:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [6:0]         neighbor;
      logic signed [15:0] weight_out;
      logic [4:0]         list_length;
      logic [11:0]        edge_total;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]             neighbor;
      logic [WEIGHT_BITS-1:0] weight;
   } entry_type;

   // flat address of one list slot
   function automatic logic [ENTRY_ADDR_BITS-1:0] entry_addr(
      input logic [6:0]          vtx,
      input logic [IDX_BITS-1:0] idx
   );
      logic [ENTRY_ADDR_BITS-1:0] base;
      base = ENTRY_ADDR_BITS'(vtx) * ENTRY_ADDR_BITS'(LIST_DEPTH);
      return base + ENTRY_ADDR_BITS'(idx);
   endfunction

endpackage

### hw/rtl/ales_ram.sv
// ales_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ales_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/adjacency_list_edge_store.sv
// adjacency_list_edge_store: directed weighted graph as fixed-depth adjacency lists.
// Depends on ales_pkg and ales_ram (entry store and list length store).
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_ready  | ales_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_ready  | ales_pkg::rsp_type
//  csr     | in        | csr_valid/csr_ready  | num_vertices, 8 bits
//
// One word at a time. Insert, clear, unknown and rejected words go from decode
// straight to the result; remove and exists compare one entry at a time
// (newest first), and remove then moves each later entry down; list gives one word
// per entry. The single compare unit and the one read port of the entry RAM set this pace.
// Reset is synchronous; list lengths are cleared at once through per-vertex
// valid bits, so no clearing pass is needed. A stalled rsp holds the sequencer.
`timescale 1ns / 1ps

module adjacency_list_edge_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ales_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ales_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SEARCH = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_LIST   = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   ales_pkg::req_type req_ff;
   logic [ales_pkg::LEN_BITS-1:0]  len_ff, len_in;
   logic [ales_pkg::IDX_BITS-1:0]  idx_ff, idx_in;
   logic [1:0]                     res_status_ff, res_status_in;
   logic                           res_found_ff, res_found_in;
   logic [15:0]                    res_weight_ff, res_weight_in;
   logic [ales_pkg::LEN_BITS-1:0]  res_len_ff, res_len_in;
   logic [ales_pkg::EDGE_BITS-1:0] edge_count_ff, edge_count_in;
   logic [ales_pkg::CFG_BITS-1:0]  cfg_ff;
   logic [ales_pkg::MAX_VERTICES-1:0] len_valid_ff, len_valid_in;
   logic              rsp_valid_ff;
   ales_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic              rsp_load;

   logic                                 entry_we;
   logic [ales_pkg::ENTRY_ADDR_BITS-1:0] entry_waddr;
   ales_pkg::entry_type                  entry_wdata;
   ales_pkg::entry_type                  entry_rdata;
   logic [ales_pkg::ENTRY_ADDR_BITS-1:0] entry_raddr;
   logic                                 len_we;
   logic [ales_pkg::LEN_BITS-1:0]        len_wdata;
   logic [ales_pkg::LEN_BITS-1:0]        len_rdata;

   logic [ales_pkg::CFG_BITS-1:0] limit;
   logic                          src_bad, tgt_bad;
   logic [ales_pkg::LEN_BITS-1:0] len_now;
   logic                          idx_at_end;
   logic                          slot_free;
   logic                          hit;

   ales_ram #(
      .WIDTH ($bits(ales_pkg::entry_type)),
      .DEPTH (ales_pkg::ENTRY_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_waddr),
      .wr_data (entry_wdata),
      .rd_addr (entry_raddr),
      .rd_data (entry_rdata)
   );

   ales_ram #(
      .WIDTH (ales_pkg::LEN_BITS),
      .DEPTH (ales_pkg::MAX_VERTICES)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (req_ff.source_vertex),
      .wr_data (len_wdata),
      .rd_addr (req_payload.source_vertex),
      .rd_data (len_rdata)
   );

   assign limit   = (cfg_ff > ales_pkg::VTX_CAP) ? ales_pkg::VTX_CAP : cfg_ff;
   assign src_bad = {1'b0, req_ff.source_vertex} >= limit;
   assign tgt_bad = {1'b0, req_ff.target_vertex} >= limit;
   assign len_now = len_valid_ff[req_ff.source_vertex] ? len_rdata : '0;
   assign idx_at_end = (ales_pkg::LEN_BITS'(idx_ff) + ales_pkg::LEN_BITS'(1)) == len_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign hit        = entry_rdata.neighbor == req_ff.target_vertex;

   // the read address follows the next index, so read data always matches idx_ff
   assign entry_raddr = ales_pkg::entry_addr(req_ff.source_vertex, idx_in);

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_weight_in = res_weight_ff;
      res_len_in    = res_len_ff;
      edge_count_in = edge_count_ff;
      len_valid_in  = len_valid_ff;
      entry_we      = 1'b0;
      entry_waddr   = ales_pkg::entry_addr(req_ff.source_vertex, idx_ff - 1'b1);
      entry_wdata   = entry_rdata;
      len_we        = 1'b0;
      len_wdata     = len_ff - 1'b1;
      rsp_load      = 1'b0;
      rsp_payload_in = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            len_in        = len_now;
            res_status_in = ales_pkg::STATUS_OK;
            res_found_in  = 1'b0;
            res_weight_in = '0;
            res_len_in    = '0;
            state_in      = S_OUT;
            if (req_ff.operation == ales_pkg::OP_CLEAR) begin
               len_valid_in  = '0;
               edge_count_in = '0;
            end else if (req_ff.operation inside {ales_pkg::OP_INSERT, ales_pkg::OP_REMOVE,
                                                 ales_pkg::OP_EXISTS, ales_pkg::OP_LIST}) begin
               if (src_bad || (req_ff.operation != ales_pkg::OP_LIST && tgt_bad)) begin
                  res_status_in = ales_pkg::STATUS_BAD_VERTEX;
               end else if (req_ff.operation == ales_pkg::OP_INSERT) begin
                  if (len_now >= ales_pkg::LEN_FULL) begin
                     res_status_in = ales_pkg::STATUS_FULL;
                     res_len_in    = len_now;
                  end else begin
                     entry_we    = 1'b1;
                     entry_waddr = ales_pkg::entry_addr(req_ff.source_vertex,
                                                        ales_pkg::IDX_BITS'(len_now));
                     entry_wdata.neighbor = req_ff.target_vertex;
                     entry_wdata.weight   =
                        ales_pkg::WEIGHT_BITS'($unsigned(req_ff.edge_weight));
                     len_we    = 1'b1;
                     len_wdata = len_now + 1'b1;
                     len_valid_in[req_ff.source_vertex] = 1'b1;
                     edge_count_in = edge_count_ff + 1'b1;
                     res_len_in    = len_now + 1'b1;
                  end
               end else if (req_ff.operation == ales_pkg::OP_LIST) begin
                  if (len_now != '0) begin
                     idx_in   = '0;
                     state_in = S_LIST;
                  end
               end else begin
                  if (len_now == '0) begin
                     res_status_in = ales_pkg::STATUS_NOT_FOUND;
                  end else begin
                     // search from the newest entry
                     idx_in   = ales_pkg::IDX_BITS'(len_now - 1'b1);
                     state_in = S_SEARCH;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               res_status_in = ales_pkg::STATUS_OK;
               res_found_in  = 1'b1;
               res_len_in    = len_ff;
               if (req_ff.operation == ales_pkg::OP_EXISTS) begin
                  state_in = S_OUT;
               end else begin
                  res_weight_in = 16'(entry_rdata.weight);
                  if (idx_at_end) begin
                     len_we     = 1'b1;
                     res_len_in = len_ff - 1'b1;
                     if (edge_count_ff != '0) begin
                        edge_count_in = edge_count_ff - 1'b1;
                     end
                     state_in = S_OUT;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_SHIFT;
                  end
               end
            end else if (idx_ff == '0) begin
               res_status_in = ales_pkg::STATUS_NOT_FOUND;
               res_len_in    = len_ff;
               state_in      = S_OUT;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         S_SHIFT: begin
            // move the entry one slot down to close the gap
            entry_we = 1'b1;
            if (idx_at_end) begin
               len_we     = 1'b1;
               res_len_in = len_ff - 1'b1;
               if (edge_count_ff != '0) begin
                  edge_count_in = edge_count_ff - 1'b1;
               end
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LIST: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_payload_in.status      = ales_pkg::STATUS_OK;
               rsp_payload_in.neighbor    = entry_rdata.neighbor;
               rsp_payload_in.weight_out  = 16'(entry_rdata.weight);
               rsp_payload_in.list_length = 5'(len_ff);
               rsp_payload_in.edge_total  = 12'(edge_count_ff);
               rsp_payload_in.last        = idx_at_end;
               if (idx_at_end) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_payload_in.status      = res_status_ff;
               rsp_payload_in.found       = res_found_ff;
               rsp_payload_in.weight_out  = res_weight_ff;
               rsp_payload_in.list_length = 5'(res_len_ff);
               rsp_payload_in.edge_total  = 12'(edge_count_ff);
               rsp_payload_in.last        = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edge_count_ff <= '0;
         len_valid_ff  <= '0;
         cfg_ff        <= ales_pkg::CFG_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         len_valid_ff  <= len_valid_in;
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_weight_ff <= res_weight_in;
      res_len_ff    <= res_len_in;
   end

endmodule

### hw/rtl/ales_checker.sv
// ales_checker: port-level checks for adjacency_list_edge_store, bound to the top level.
// Depends on ales_pkg; sees the top level's ports only.
`timescale 1ns / 1ps

module ales_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ales_pkg::rsp_type rsp_payload
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp word dropped or changed while stalled");

   // the block is busy the cycle after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken again straight after accept");

   // more list words to come: no new request may be taken yet
   a_list_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> !req_ready)
      else $error("req ready before the last word of a list");

   // a full list reports its full length
   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ales_pkg::STATUS_FULL
         |-> rsp_payload.list_length == 5'(ales_pkg::LEN_FULL) && rsp_payload.last)
      else $error("list full reported with wrong length");

endmodule

bind adjacency_list_edge_store ales_checker u_ales_checker (.*);
